FILE: hw/rtl/sba_pkg.sv
// shared types, constants and helpers for the signed byte alu
package sba_pkg;

  localparam int unsigned DataW         = 8;
  localparam int unsigned AccW          = DataW + 1;
  localparam int unsigned ModeW         = 3;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumDivStages  = DataW / StepsPerStage;

  localparam logic [DataW-1:0] NegOneAdd = DataW'(1);

  typedef enum logic [ModeW-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MOD = 3'd4
  } mode_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [AccW-1:0]  acc;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
    logic             neg;
    logic [DataW-1:0] res;
    logic             carry;
    logic             dz;
  } stage_t;

  function automatic logic [DataW-1:0] neg_byte(logic [DataW-1:0] v);
    return ~v + NegOneAdd;
  endfunction

  function automatic logic [DataW-1:0] mag_byte(logic [DataW-1:0] v);
    return v[DataW-1] ? neg_byte(v) : v;
  endfunction

endpackage

FILE: hw/rtl/sba_if.sv
// valid/ready channel interfaces for operations and results
interface sba_in_if;
  logic                              valid;
  logic                              ready;
  logic        [sba_pkg::ModeW-1:0]  mode;
  logic signed [sba_pkg::DataW-1:0]  operand_a;
  logic signed [sba_pkg::DataW-1:0]  operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface sba_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sba_pkg::DataW-1:0]  result;
  logic                              carry_out;
  logic                              divide_by_zero;

  modport source (output valid, result, carry_out, divide_by_zero, input ready);
  modport sink   (input valid, result, carry_out, divide_by_zero, output ready);
endinterface

FILE: hw/rtl/sba_front.sv
// first pipeline stage: decode, add/sub/mul and divider setup
module sba_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic                         valid_i,
  input  logic [sba_pkg::ModeW-1:0]    mode_i,
  input  logic [sba_pkg::DataW-1:0]    operand_a_i,
  input  logic [sba_pkg::DataW-1:0]    operand_b_i,
  output logic                         valid_o,
  output sba_pkg::stage_t              stage_o
);

  logic            valid_q;
  sba_pkg::stage_t stage_d, stage_q;
  logic [sba_pkg::DataW:0]     sum;
  logic [sba_pkg::DataW-1:0]   prod;
  logic                        is_div;

  always_comb begin
    sum    = {1'b0, operand_a_i} + {1'b0, operand_b_i};
    prod   = operand_a_i * operand_b_i;
    is_div = (mode_i == sba_pkg::MODE_DIV) || (mode_i == sba_pkg::MODE_MOD);

    stage_d       = '0;
    stage_d.mode  = mode_i;
    stage_d.quo   = sba_pkg::mag_byte(operand_a_i);
    stage_d.dvs   = sba_pkg::mag_byte(operand_b_i);
    stage_d.neg   = operand_a_i[sba_pkg::DataW-1] ^ operand_b_i[sba_pkg::DataW-1];
    stage_d.dz    = is_div && (operand_b_i == '0);
    case (mode_i)
      sba_pkg::MODE_ADD: begin
        stage_d.res   = sum[sba_pkg::DataW-1:0];
        stage_d.carry = sum[sba_pkg::DataW];
      end
      sba_pkg::MODE_SUB: begin
        stage_d.res = operand_a_i + sba_pkg::neg_byte(operand_b_i);
      end
      sba_pkg::MODE_MUL: begin
        stage_d.res = prod;
      end
      default: begin
        stage_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/sba_div_stage.sv
// restoring divider stage: two quotient bits per register stage
module sba_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            valid_i,
  input  sba_pkg::stage_t stage_i,
  output logic            valid_o,
  output sba_pkg::stage_t stage_o
);

  logic            valid_q;
  sba_pkg::stage_t stage_d, stage_q;

  always_comb begin
    stage_d = stage_i;
    for (int unsigned s = 0; s < sba_pkg::StepsPerStage; s++) begin
      stage_d.acc = {stage_d.acc[sba_pkg::DataW-1:0], stage_d.quo[sba_pkg::DataW-1]};
      stage_d.quo = {stage_d.quo[sba_pkg::DataW-2:0], 1'b0};
      if (stage_d.acc >= {1'b0, stage_d.dvs}) begin
        stage_d.acc    = stage_d.acc - {1'b0, stage_d.dvs};
        stage_d.quo[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/signed_byte_alu_booth_restoring.sv
// top level of the signed byte alu pipeline
//
// Operations arrive on in_i (mode, operand_a, operand_b) and results leave on
// out_o (result, carry_out, divide_by_zero), both valid/ready channels; a
// transaction happens when valid and ready are high at a rising clock edge.
// Every operation yields exactly one result, in order.
// Each accepted operation passes in order through the registered stages:
// one decode stage, four restoring divider stages of two quotient bits each
// and the output register. All modes take the same path through the pipe.
// Throughput: one operation per cycle while the receiver keeps ready high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_i.ready drops; ready stays high while the output register is empty or
// being read. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; the block is ready
// in the first cycle after reset and keeps no state between operations.
// A zero divisor on divide or modulo returns 0 with divide_by_zero set;
// unused modes return 0 with both flags clear.
module signed_byte_alu_booth_restoring (
  input  logic      clk_i,
  input  logic      rst_ni,
  sba_in_if.sink    in_i,
  sba_out_if.source out_o
);

  logic advance;
  logic [sba_pkg::NumDivStages:0] valid_pipe;
  sba_pkg::stage_t                stage_pipe [sba_pkg::NumDivStages+1];

  logic                     out_valid_q;
  logic [sba_pkg::DataW-1:0] result_d, result_q;
  logic                     carry_d, carry_q;
  logic                     dz_d, dz_q;
  sba_pkg::stage_t          last;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  sba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .valid_i     (in_i.valid),
    .mode_i      (in_i.mode),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .valid_o     (valid_pipe[0]),
    .stage_o     (stage_pipe[0])
  );

  for (genvar g = 0; g < sba_pkg::NumDivStages; g++) begin : g_div
    sba_div_stage u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (valid_pipe[g]),
      .stage_i   (stage_pipe[g]),
      .valid_o   (valid_pipe[g+1]),
      .stage_o   (stage_pipe[g+1])
    );
  end

  assign last = stage_pipe[sba_pkg::NumDivStages];

  always_comb begin
    carry_d = last.carry;
    dz_d    = last.dz;
    case (last.mode)
      sba_pkg::MODE_DIV: begin
        result_d = last.neg ? sba_pkg::neg_byte(last.quo) : last.quo;
      end
      sba_pkg::MODE_MOD: begin
        result_d = last.acc[sba_pkg::DataW-1:0];
      end
      default: begin
        result_d = last.res;
      end
    endcase
    if (last.dz) begin
      result_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_pipe[sba_pkg::NumDivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
      carry_q  <= carry_d;
      dz_q     <= dz_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result         = result_q;
  assign out_o.carry_out      = carry_q;
  assign out_o.divide_by_zero = dz_q;

`ifndef SYNTHESIS
  a_dz_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dz_q |-> (result_q == '0) && !carry_q)
    else $error("divide by zero result not cleared");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(carry_q && dz_q))
    else $error("carry and divide by zero both set");

  a_stall_holds_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid_pipe) && out_valid_q)
    else $error("pipeline moved during stall");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

FILE: tb/tb_top.sv
// testbench for the signed byte alu: directed table, then random traffic checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PhaseItems  = 610;
  localparam int unsigned DrainCycles = 8;

  localparam logic [sba_pkg::ModeW-1:0] MODE_SPARE0 = 3'd5;
  localparam logic [sba_pkg::ModeW-1:0] MODE_SPARE1 = 3'd6;
  localparam logic [sba_pkg::ModeW-1:0] MODE_SPARE2 = 3'd7;

  typedef struct packed {
    logic [sba_pkg::DataW-1:0] result;
    logic                      carry_out;
    logic                      divide_by_zero;
  } alu_result_t;

  typedef struct packed {
    logic [sba_pkg::ModeW-1:0] mode;
    logic [sba_pkg::DataW-1:0] a;
    logic [sba_pkg::DataW-1:0] b;
    logic                      known;
    logic [sba_pkg::DataW-1:0] res;
    logic                      carry;
    logic                      dz;
  } directed_op_t;

  logic clk;
  logic rst_n;

  sba_in_if  in_if ();
  sba_out_if out_if ();

  signed_byte_alu_booth_restoring u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  alu_result_t  expected_q [$];
  directed_op_t directed_ops [25];
  int unsigned  mismatch_count;
  int unsigned  stall_cycles;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_stamp;
  int unsigned  hold_seen;
  int unsigned  hold_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic alu_result_t predict_alu(logic [sba_pkg::ModeW-1:0] mode,
                                              logic [sba_pkg::DataW-1:0] a,
                                              logic [sba_pkg::DataW-1:0] b);
    alu_result_t                 r;
    logic [sba_pkg::DataW:0]     sum;
    logic [2*sba_pkg::DataW-1:0] prod;
    logic [sba_pkg::DataW-1:0]   mag_a;
    logic [sba_pkg::DataW-1:0]   mag_b;
    logic [sba_pkg::DataW-1:0]   quo;
    r = '0;
    case (mode)
      sba_pkg::MODE_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r.result = sum[sba_pkg::DataW-1:0];
        r.carry_out = sum[sba_pkg::DataW];
      end
      sba_pkg::MODE_SUB: begin
        r.result = a + (~b + 8'd1);
      end
      sba_pkg::MODE_MUL: begin
        prod = {8'd0, a} * {8'd0, b};
        r.result = prod[sba_pkg::DataW-1:0];
      end
      sba_pkg::MODE_DIV, sba_pkg::MODE_MOD: begin
        if (b == '0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          mag_a = a[sba_pkg::DataW-1] ? ~a + 8'd1 : a;
          mag_b = b[sba_pkg::DataW-1] ? ~b + 8'd1 : b;
          if (mode == sba_pkg::MODE_DIV) begin
            quo = mag_a / mag_b;
            r.result = (a[sba_pkg::DataW-1] ^ b[sba_pkg::DataW-1]) ? ~quo + 8'd1 : quo;
          end else begin
            r.result = mag_a % mag_b;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [sba_pkg::DataW-1:0] pick_operand();
    logic [sba_pkg::DataW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 8'h80;
          1: v = 8'hFF;
          2: v = 8'h00;
          3: v = 8'h01;
          default: v = 8'h7F;
        endcase
      end
      1, 2: v = 8'($urandom_range(8)) - 8'd4;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_op(logic [sba_pkg::ModeW-1:0] mode, logic [sba_pkg::DataW-1:0] a,
                         logic [sba_pkg::DataW-1:0] b, alu_result_t exp_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk); while (!in_if.ready);
    expected_q.push_back(exp_res);
  endtask

  // receiver side, with a single long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_stamp) begin
      hold_seen    <= hold_stamp;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, result %h carry %b dz %b", $time,
                 out_if.result, out_if.carry_out, out_if.divide_by_zero);
        mismatch_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_if.result !== exp_res.result) begin
          $display("%0t: result mismatch, expected %h, actual %h", $time,
                   exp_res.result, out_if.result);
          mismatch_count++;
        end
        if (out_if.carry_out !== exp_res.carry_out) begin
          $display("%0t: carry_out mismatch, expected %b, actual %b", $time,
                   exp_res.carry_out, out_if.carry_out);
          mismatch_count++;
        end
        if (out_if.divide_by_zero !== exp_res.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch, expected %b, actual %b", $time,
                   exp_res.divide_by_zero, out_if.divide_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [sba_pkg::ModeW-1:0] mode;
    logic [sba_pkg::DataW-1:0] a;
    logic [sba_pkg::DataW-1:0] b;
    alu_result_t               exp_res;

    directed_ops = '{
      '{sba_pkg::MODE_ADD, 8'h7F, 8'h01, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_ADD, 8'hFF, 8'hFF, 1'b1, 8'hFE, 1'b1, 1'b0},
      '{sba_pkg::MODE_ADD, 8'h80, 8'h80, 1'b1, 8'h00, 1'b1, 1'b0},
      '{sba_pkg::MODE_ADD, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_SUB, 8'h00, 8'h80, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_SUB, 8'h80, 8'h01, 1'b1, 8'h7F, 1'b0, 1'b0},
      '{sba_pkg::MODE_SUB, 8'h7F, 8'hFF, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_MUL, 8'h80, 8'hFF, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_MUL, 8'h7F, 8'h7F, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_MUL, 8'h80, 8'h80, 1'b1, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_MUL, 8'hFD, 8'h05, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_DIV, 8'h80, 8'h01, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_DIV, 8'h80, 8'hFF, 1'b1, 8'h80, 1'b0, 1'b0},
      '{sba_pkg::MODE_DIV, 8'h05, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
      '{sba_pkg::MODE_DIV, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
      '{sba_pkg::MODE_DIV, 8'h7F, 8'h80, 1'b1, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_DIV, 8'hF9, 8'h02, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_DIV, 8'h64, 8'hF9, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_MOD, 8'h05, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
      '{sba_pkg::MODE_MOD, 8'h80, 8'h03, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_MOD, 8'hF9, 8'h02, 1'b0, 8'h00, 1'b0, 1'b0},
      '{sba_pkg::MODE_MOD, 8'h80, 8'h80, 1'b1, 8'h00, 1'b0, 1'b0},
      '{MODE_SPARE0,       8'h7F, 8'h7F, 1'b1, 8'h00, 1'b0, 1'b0},
      '{MODE_SPARE1,       8'h80, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0},
      '{MODE_SPARE2,       8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0}
    };

    mismatch_count  = 0;
    stall_cycles    = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_stamp      = 0;
    hold_seen       = 0;
    hold_left       = 0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = '0;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    out_if.ready    = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      if (directed_ops[i].known) begin
        exp_res = '{directed_ops[i].res, directed_ops[i].carry, directed_ops[i].dz};
      end else begin
        exp_res = predict_alu(directed_ops[i].mode, directed_ops[i].a, directed_ops[i].b);
      end
      send_op(directed_ops[i].mode, directed_ops[i].a, directed_ops[i].b, exp_res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // long receiver hold-off so the pipe fills and backs up the input
          hold_stamp++;
        end
      endcase
      repeat (PhaseItems) begin
        if ($urandom_range(19) == 0) begin
          mode = 3'($urandom_range(MODE_SPARE2, MODE_SPARE0));
        end else begin
          mode = 3'($urandom_range(sba_pkg::MODE_MOD));
        end
        a = pick_operand();
        b = pick_operand();
        send_op(mode, a, b, predict_alu(mode, a, b));
      end
    end
    in_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
